FILE: src/next_fit_coalescing_allocator_macros.svh
`ifndef NEXT_FIT_COALESCING_ALLOCATOR_MACROS_SVH
`define NEXT_FIT_COALESCING_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define NFCA_AST_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NFCA_AST_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/nfca_pkg.sv
package nfca_pkg;

	localparam int FREE_ENTRIES_DEF   = 64;
	localparam int UNIT_ADDR_BITS_DEF = 24;
	localparam int REQ_W              = 28;
	// units needed for a request: bytes / 16 rounded up, plus header
	localparam int N_W                = REQ_W - 3;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EXHAUSTED = 2'd1,
		ST_TBL_FULL  = 2'd2,
		ST_ZERO      = 2'd3
	} status_t;

	typedef enum logic {
		FUNC_ALLOC = 1'b0,
		FUNC_FREE  = 1'b1
	} func_t;

	typedef enum logic {
		CFG_HEAP_START = 1'b0,
		CFG_HEAP_END   = 1'b1
	} cfg_idx_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef struct packed {
		logic eq;   // result equals compare operand
		logic ge;   // result at or above compare operand
		logic neg;  // subtraction borrowed
	} alu_flags_t;

endpackage

FILE: src/nfca_alu.sv
module nfca_alu #(
	parameter int DW = 27
) (
	input  nfca_pkg::alu_op_t    op,
	input  logic [DW-1:0]        a,
	input  logic [DW-1:0]        b,
	input  logic [DW-1:0]        c,
	output logic [DW-1:0]        res,
	output nfca_pkg::alu_flags_t flags
);

	always_comb begin
		if (op == nfca_pkg::ALU_SUB) begin
			res = a - b;
		end else begin
			res = a + b;
		end
		flags.eq  = (res == c);
		flags.ge  = (res >= c);
		flags.neg = res[DW-1];
	end

endmodule

FILE: src/nfca_mem.sv
module nfca_mem #(
	parameter int DEPTH = 64,
	parameter int IW    = 6,
	parameter int AW    = 24,
	parameter int SW    = 25
) (
	input  logic          clk,
	input  logic          we,
	input  logic [IW-1:0] waddr,
	input  logic [AW-1:0] wstart,
	input  logic [SW-1:0] wsize,
	input  logic [IW-1:0] raddr,
	output logic [AW-1:0] rstart,
	output logic [SW-1:0] rsize
);

	logic [AW-1:0] start_mem [DEPTH];
	logic [SW-1:0] size_mem  [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			start_mem[waddr] <= wstart;
			size_mem[waddr]  <= wsize;
		end
		rstart <= start_mem[raddr];
		rsize  <= size_mem[raddr];
	end

endmodule

FILE: src/next_fit_coalescing_allocator.sv
// channel  dir  handshake            payload
// req      in   req_valid/req_stall  func, request_bytes, release_address, release_units
// rsp      out  rsp_valid/rsp_stall  grant_address, grant_units, status
// cfg      in   cfg_we               cfg_index, cfg_data
// One request at a time; a table walk reads one extent after another through the
// table's read port and the shared adder. The slowest path runs search, growth insert
// with shift, then carve with removal; a zero request goes straight to the response.
// arst_n clears the extent count, rover and registers; the table needs no clearing.
// A finished response sits in the output register; the next request is taken meanwhile.
`include "next_fit_coalescing_allocator_macros.svh"

module next_fit_coalescing_allocator #(
	parameter int FREE_ENTRIES   = nfca_pkg::FREE_ENTRIES_DEF,
	parameter int UNIT_ADDR_BITS = nfca_pkg::UNIT_ADDR_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic                        func,
	input  logic [nfca_pkg::REQ_W-1:0]  request_bytes,
	input  logic [UNIT_ADDR_BITS-1:0]   release_address,
	input  logic [UNIT_ADDR_BITS:0]     release_units,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic [UNIT_ADDR_BITS-1:0]   grant_address,
	output logic [UNIT_ADDR_BITS:0]     grant_units,
	output nfca_pkg::status_t           status,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [UNIT_ADDR_BITS:0]     cfg_data
);

	localparam int AW = UNIT_ADDR_BITS;
	localparam int SW = AW + 1;
	localparam int NW = nfca_pkg::N_W;
	localparam int DW = ((SW > NW) ? SW : NW) + 1;
	localparam int IW = $clog2(FREE_ENTRIES);
	localparam int CW = $clog2(FREE_ENTRIES + 1);
	localparam logic [SW-1:0] HEAP_LIM = SW'(1) << AW;

	typedef enum logic [19:0] {
		S_IDLE     = 20'h00001,
		S_SRCH_RD  = 20'h00002,
		S_SRCH_CK  = 20'h00004,
		S_GROW_CK  = 20'h00008,
		S_INS_INIT = 20'h00010,
		S_INS_RD   = 20'h00020,
		S_INS_CK   = 20'h00040,
		S_INS_LOW  = 20'h00080,
		S_INS_UP   = 20'h00100,
		S_INS_ACT  = 20'h00200,
		S_INS_MRG2 = 20'h00400,
		S_SH_RD    = 20'h00800,
		S_SH_WR    = 20'h01000,
		S_INS_END  = 20'h02000,
		S_CRV_SUB  = 20'h04000,
		S_CRV_FIN  = 20'h08000,
		S_RM_RD    = 20'h10000,
		S_RM_WR    = 20'h20000,
		S_RM_END   = 20'h40000,
		S_DONE     = 20'h80000
	} state_t;

	state_t state_q;

	logic [CW-1:0] cnt_q;
	logic [IW-1:0] rover_q;
	logic [SW-1:0] top_q;
	logic [SW-1:0] he_q;

	logic [NW-1:0] n_q;
	logic [AW-1:0] ins_start_q;
	logic [SW-1:0] ins_size_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] k_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] hold_idx_q;
	logic [AW-1:0] prev_start_q;
	logic [SW-1:0] prev_size_q;
	logic [AW-1:0] cur_start_q;
	logic [SW-1:0] cur_size_q;
	logic [SW-1:0] newsize_q;
	logic [SW-1:0] diff_q;
	logic          exact_q;
	logic          lower_q;
	logic          upper_q;
	logic          grow_q;
	logic          ret_carve_q;

	logic [AW-1:0]     res_addr_q;
	logic [SW-1:0]     res_units_q;
	nfca_pkg::status_t res_status_q;

	logic                 rsp_valid_q;
	logic [AW-1:0]        rsp_addr_q;
	logic [SW-1:0]        rsp_units_q;
	nfca_pkg::status_t    rsp_status_q;

	nfca_pkg::alu_op_t    alu_op;
	logic [DW-1:0]        alu_a, alu_b, alu_c, alu_res;
	nfca_pkg::alu_flags_t alu_flags;
	logic [SW-1:0]        sat;
	logic [SW-1:0]        limit;

	logic          mem_we;
	logic [IW-1:0] mem_waddr, mem_raddr;
	logic [AW-1:0] mem_wstart, rd_start;
	logic [SW-1:0] mem_wsize, rd_size;

	logic          accept;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign limit     = (he_q < HEAP_LIM) ? he_q : HEAP_LIM;
	assign sat       = (|alu_res[DW-1:SW]) ? {SW{1'b1}} : alu_res[SW-1:0];

	assign rsp_valid     = rsp_valid_q;
	assign grant_address = rsp_addr_q;
	assign grant_units   = rsp_units_q;
	assign status        = rsp_status_q;

	nfca_alu #(.DW(DW)) u_alu (
		.op    (alu_op),
		.a     (alu_a),
		.b     (alu_b),
		.c     (alu_c),
		.res   (alu_res),
		.flags (alu_flags)
	);

	nfca_mem #(.DEPTH(FREE_ENTRIES), .IW(IW), .AW(AW), .SW(SW)) u_mem (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wstart (mem_wstart),
		.wsize  (mem_wsize),
		.raddr  (mem_raddr),
		.rstart (rd_start),
		.rsize  (rd_size)
	);

	always_comb begin
		alu_op = nfca_pkg::ALU_ADD;
		alu_a  = '0;
		alu_b  = '0;
		alu_c  = '0;
		case (state_q)
			S_SRCH_CK: begin
				alu_op = nfca_pkg::ALU_SUB;
				alu_a  = DW'(rd_size);
				alu_b  = DW'(n_q);
			end
			S_GROW_CK: begin
				alu_a = DW'(top_q);
				alu_b = DW'(n_q);
				alu_c = DW'(limit);
			end
			S_INS_CK: begin
				alu_op = nfca_pkg::ALU_SUB;
				alu_a  = DW'(rd_start);
				alu_b  = DW'(ins_start_q);
			end
			S_INS_LOW: begin
				alu_a = DW'(prev_start_q);
				alu_b = DW'(prev_size_q);
				alu_c = DW'(ins_start_q);
			end
			S_INS_UP: begin
				alu_a = DW'(ins_start_q);
				alu_b = DW'(ins_size_q);
				alu_c = DW'(cur_start_q);
			end
			S_INS_ACT: begin
				alu_a = lower_q ? DW'(prev_size_q) : DW'(cur_size_q);
				alu_b = DW'(ins_size_q);
			end
			S_INS_MRG2: begin
				alu_a = DW'(newsize_q);
				alu_b = DW'(cur_size_q);
			end
			S_INS_END: begin
				alu_a = DW'(top_q);
				alu_b = DW'(n_q);
			end
			S_CRV_SUB: begin
				alu_op = nfca_pkg::ALU_SUB;
				alu_a  = DW'(cur_size_q);
				alu_b  = DW'(n_q);
			end
			S_CRV_FIN: begin
				alu_a = DW'(cur_start_q);
				alu_b = DW'(diff_q);
			end
			default: begin
				alu_op = nfca_pkg::ALU_ADD;
			end
		endcase
	end

	always_comb begin
		mem_we     = 1'b0;
		mem_waddr  = IW'(idx_q);
		mem_wstart = rd_start;
		mem_wsize  = rd_size;
		mem_raddr  = IW'(idx_q);
		case (state_q)
			S_INS_ACT: begin
				if (lower_q && !upper_q) begin
					mem_we     = 1'b1;
					mem_waddr  = IW'(pos_q - CW'(1));
					mem_wstart = prev_start_q;
					mem_wsize  = sat;
				end else if (!lower_q && upper_q) begin
					mem_we     = 1'b1;
					mem_waddr  = IW'(pos_q);
					mem_wstart = ins_start_q;
					mem_wsize  = sat;
				end
			end
			S_INS_MRG2: begin
				mem_we     = 1'b1;
				mem_waddr  = IW'(pos_q - CW'(1));
				mem_wstart = prev_start_q;
				mem_wsize  = sat;
			end
			S_SH_RD: begin
				mem_raddr = IW'(idx_q - CW'(1));
				if (idx_q <= pos_q) begin
					mem_we     = 1'b1;
					mem_waddr  = IW'(pos_q);
					mem_wstart = ins_start_q;
					mem_wsize  = ins_size_q;
				end
			end
			S_SH_WR: begin
				mem_we = 1'b1;
			end
			S_RM_RD: begin
				mem_raddr = IW'(idx_q + CW'(1));
			end
			S_RM_WR: begin
				mem_we = 1'b1;
			end
			S_CRV_FIN: begin
				if (!exact_q) begin
					mem_we     = 1'b1;
					mem_waddr  = IW'(hold_idx_q);
					mem_wstart = cur_start_q;
					mem_wsize  = diff_q;
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			rover_q      <= '0;
			top_q        <= '0;
			he_q         <= HEAP_LIM;
			n_q          <= '0;
			ins_start_q  <= '0;
			ins_size_q   <= '0;
			idx_q        <= '0;
			k_q          <= '0;
			pos_q        <= '0;
			hold_idx_q   <= '0;
			prev_start_q <= '0;
			prev_size_q  <= '0;
			cur_start_q  <= '0;
			cur_size_q   <= '0;
			newsize_q    <= '0;
			diff_q       <= '0;
			exact_q      <= 1'b0;
			lower_q      <= 1'b0;
			upper_q      <= 1'b0;
			grow_q       <= 1'b0;
			ret_carve_q  <= 1'b0;
			res_addr_q   <= '0;
			res_units_q  <= '0;
			res_status_q <= nfca_pkg::ST_OK;
			rsp_valid_q  <= 1'b0;
			rsp_addr_q   <= '0;
			rsp_units_q  <= '0;
			rsp_status_q <= nfca_pkg::ST_OK;
		end else begin
			if (cfg_we) begin
				if (cfg_index == nfca_pkg::CFG_HEAP_START) begin
					top_q <= SW'(cfg_data[AW-1:0]);
				end else begin
					he_q <= cfg_data;
				end
			end
			if (rsp_valid_q && !rsp_stall && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_addr_q   <= '0;
						res_units_q  <= '0;
						res_status_q <= nfca_pkg::ST_OK;
						grow_q       <= 1'b0;
						n_q <= NW'(request_bytes[nfca_pkg::REQ_W-1:4])
							+ NW'(|request_bytes[3:0]) + NW'(1);
						ins_start_q  <= release_address - AW'(1);
						ins_size_q   <= release_units;
						idx_q        <= CW'(rover_q);
						k_q          <= '0;
						if (func == nfca_pkg::FUNC_FREE) begin
							if (release_units == '0) begin
								res_status_q <= nfca_pkg::ST_ZERO;
								state_q      <= S_DONE;
							end else begin
								state_q <= S_INS_INIT;
							end
						end else if (request_bytes == '0) begin
							res_status_q <= nfca_pkg::ST_ZERO;
							state_q      <= S_DONE;
						end else if (cnt_q == '0) begin
							state_q <= S_GROW_CK;
						end else begin
							state_q <= S_SRCH_RD;
						end
					end
				end
				S_SRCH_RD: begin
					state_q <= S_SRCH_CK;
				end
				S_SRCH_CK: begin
					if (!alu_flags.neg) begin
						cur_start_q <= rd_start;
						cur_size_q  <= rd_size;
						hold_idx_q  <= idx_q;
						state_q     <= S_CRV_SUB;
					end else if (k_q + CW'(1) == cnt_q) begin
						state_q <= S_GROW_CK;
					end else begin
						k_q     <= k_q + CW'(1);
						idx_q   <= (idx_q + CW'(1) == cnt_q) ? '0 : idx_q + CW'(1);
						state_q <= S_SRCH_RD;
					end
				end
				S_GROW_CK: begin
					if (alu_flags.ge) begin
						res_status_q <= nfca_pkg::ST_EXHAUSTED;
						state_q      <= S_DONE;
					end else begin
						ins_start_q <= top_q[AW-1:0];
						ins_size_q  <= SW'(n_q);
						grow_q      <= 1'b1;
						state_q     <= S_INS_INIT;
					end
				end
				S_INS_INIT: begin
					idx_q <= '0;
					if (cnt_q == '0) begin
						pos_q   <= '0;
						state_q <= S_INS_LOW;
					end else begin
						state_q <= S_INS_RD;
					end
				end
				S_INS_RD: begin
					state_q <= S_INS_CK;
				end
				S_INS_CK: begin
					if (alu_flags.neg) begin
						prev_start_q <= rd_start;
						prev_size_q  <= rd_size;
						if (idx_q + CW'(1) == cnt_q) begin
							pos_q   <= cnt_q;
							state_q <= S_INS_LOW;
						end else begin
							idx_q   <= idx_q + CW'(1);
							state_q <= S_INS_RD;
						end
					end else begin
						cur_start_q <= rd_start;
						cur_size_q  <= rd_size;
						pos_q       <= idx_q;
						state_q     <= S_INS_LOW;
					end
				end
				S_INS_LOW: begin
					lower_q <= (pos_q != '0) && alu_flags.eq;
					state_q <= S_INS_UP;
				end
				S_INS_UP: begin
					upper_q <= (pos_q < cnt_q) && alu_flags.eq;
					state_q <= S_INS_ACT;
				end
				S_INS_ACT: begin
					if (lower_q) begin
						hold_idx_q  <= pos_q - CW'(1);
						cur_start_q <= prev_start_q;
						newsize_q   <= sat;
						if (upper_q) begin
							state_q <= S_INS_MRG2;
						end else begin
							cur_size_q <= sat;
							state_q    <= S_INS_END;
						end
					end else if (upper_q) begin
						hold_idx_q  <= pos_q;
						cur_start_q <= ins_start_q;
						cur_size_q  <= sat;
						state_q     <= S_INS_END;
					end else if (cnt_q >= CW'(FREE_ENTRIES)) begin
						res_status_q <= nfca_pkg::ST_TBL_FULL;
						state_q      <= S_DONE;
					end else begin
						hold_idx_q  <= pos_q;
						cur_start_q <= ins_start_q;
						cur_size_q  <= ins_size_q;
						idx_q       <= cnt_q;
						state_q     <= S_SH_RD;
					end
				end
				S_INS_MRG2: begin
					cur_size_q  <= sat;
					idx_q       <= pos_q;
					ret_carve_q <= 1'b0;
					state_q     <= S_RM_RD;
				end
				S_SH_RD: begin
					if (idx_q > pos_q) begin
						state_q <= S_SH_WR;
					end else begin
						cnt_q   <= cnt_q + CW'(1);
						state_q <= S_INS_END;
					end
				end
				S_SH_WR: begin
					idx_q   <= idx_q - CW'(1);
					state_q <= S_SH_RD;
				end
				S_INS_END: begin
					rover_q <= (pos_q < cnt_q) ? IW'(pos_q) : '0;
					if (grow_q) begin
						top_q   <= alu_res[SW-1:0];
						state_q <= S_CRV_SUB;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_CRV_SUB: begin
					diff_q  <= alu_res[SW-1:0];
					exact_q <= (alu_res == '0);
					state_q <= S_CRV_FIN;
				end
				S_CRV_FIN: begin
					res_units_q <= SW'(n_q);
					if (exact_q) begin
						res_addr_q  <= cur_start_q + AW'(1);
						idx_q       <= hold_idx_q;
						ret_carve_q <= 1'b1;
						state_q     <= S_RM_RD;
					end else begin
						res_addr_q <= alu_res[AW-1:0] + AW'(1);
						rover_q    <= IW'(hold_idx_q);
						state_q    <= S_DONE;
					end
				end
				S_RM_RD: begin
					if (idx_q + CW'(1) < cnt_q) begin
						state_q <= S_RM_WR;
					end else begin
						cnt_q   <= cnt_q - CW'(1);
						state_q <= S_RM_END;
					end
				end
				S_RM_WR: begin
					idx_q   <= idx_q + CW'(1);
					state_q <= S_RM_RD;
				end
				S_RM_END: begin
					if (ret_carve_q) begin
						rover_q <= (hold_idx_q < cnt_q) ? IW'(hold_idx_q) : '0;
						state_q <= S_DONE;
					end else begin
						state_q <= S_INS_END;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q  <= 1'b1;
						rsp_addr_q   <= res_addr_q;
						rsp_units_q  <= res_units_q;
						rsp_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`NFCA_AST_IMP(a_cnt_bound, 1'b1, cnt_q <= CW'(FREE_ENTRIES), "extent count above table depth")
	`NFCA_AST_NXT(a_busy_after_req, accept, state_q != S_IDLE, "accepted request left block idle")
	`NFCA_AST_IMP(a_rover_range, state_q == S_IDLE, (rover_q == '0) || (CW'(rover_q) < cnt_q), "rover outside table")
	`NFCA_AST_IMP(a_fail_no_grant, (state_q == S_DONE) && (res_status_q != nfca_pkg::ST_OK), (res_units_q == '0) && (res_addr_q == '0), "failed request carries a grant")

endmodule
